@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/rc5_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rc5_pkg;

	localparam logic [31:0] MAGIC_P = 32'hb7e15163;
	localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;
	localparam int KEY_WORDS = 4;
	localparam logic [4:0] MIX_ROT = 5'd3;

	localparam logic [1:0] OP_ENC = 2'd0;
	localparam logic [1:0] OP_DEC = 2'd1;
	localparam logic [1:0] OP_EXPAND = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] REG_KEY_LOW = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;

	// Per-cell control of a ring of storage cells.
	typedef struct packed {
		logic ld;
		logic fwd;
		logic bwd;
	} cell_ctl_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} << n;
		return t[63:32];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] t;
		t = {x, x} >> n;
		return t[31:0];
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rc5_block_cipher_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Handshake                   | Payload
// command   | in        | start, busy                 | opcode, word_a, word_b
// result    | out       | done (one-cycle strobe)     | out_a, out_b, status
// key write | in        | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
// Encrypt and decrypt run one round per cycle, paced by the round logic reading
// one subkey pair cell per cycle. Key expansion seeds the ring pair by pair,
// then mixes one subkey word per cycle over three mixing passes.
// Errors and the unused opcode answer in the cycle after start.
// arst_n clears control state and the key registers; the subkey ring has no
// reset. The result word is shown for one cycle and cannot be stalled.
module rc5_block_cipher_top #(
	parameter int ROUNDS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] opcode,
	input wire logic [31:0] word_a,
	input wire logic [31:0] word_b,
	output logic done,
	output logic [31:0] out_a,
	output logic [31:0] out_b,
	output logic status,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data
);

	// The subkey table lives in a ring of N cells, each holding the pair
	// S[2r] (low half) and S[2r+1] (high half).
	localparam int N = ROUNDS + 1;
	localparam int MIX_STEPS = 6 * N;
	localparam int CW = $clog2(MIX_STEPS);
	localparam logic [CW-1:0] LAST_PAIR = CW'(N - 1);
	localparam logic [CW-1:0] LAST_MIX = CW'(MIX_STEPS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ENC = 3'd1;
	localparam logic [2:0] ST_DEC = 3'd2;
	localparam logic [2:0] ST_SEED = 3'd3;
	localparam logic [2:0] ST_MIX = 3'd4;

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] a_q, b_q, v_q;
	logic [63:0] key_low_q, key_high_q;
	logic table_ready_q;
	logic done_q, status_q;
	logic [31:0] out_a_q, out_b_q;

	logic [63:0] sq [N];
	logic [31:0] lq [rc5_pkg::KEY_WORDS];
	rc5_pkg::cell_ctl_t s_ctl, l_ctl;
	logic s_ld;
	logic [63:0] s_tail_in, s_ld_d;

	logic [63:0] head, tail;
	logic [31:0] enc_a, enc_b, dec_a, dec_b;
	logic [31:0] mix_sel, mix_a, mix_ab, mix_b;
	logic accept;

	assign head = sq[0];
	assign tail = sq[N-1];
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Round datapath: encryption reads the head pair, decryption the tail; key mixing also reads the head.
	always_comb begin
		enc_a = rc5_pkg::rotl32(a_q ^ b_q, b_q[4:0]) + head[31:0];
		enc_b = rc5_pkg::rotl32(b_q ^ enc_a, enc_a[4:0]) + head[63:32];
		dec_b = rc5_pkg::rotr32(b_q - tail[63:32], a_q[4:0]) ^ a_q;
		dec_a = rc5_pkg::rotr32(a_q - tail[31:0], dec_b[4:0]) ^ dec_b;
		mix_sel = cnt_q[0] ? head[63:32] : head[31:0];
		mix_a = rc5_pkg::rotl32(mix_sel + a_q + b_q, rc5_pkg::MIX_ROT);
		mix_ab = mix_a + b_q;
		mix_b = rc5_pkg::rotl32(lq[0] + mix_ab, mix_ab[4:0]);
	end

	// Ring steering. A mixing step on a high half writes the updated pair
	// back through the tail while the ring turns forward.
	always_comb begin
		s_ctl = '0;
		l_ctl = '0;
		s_ld = 1'b0;
		s_ld_d = {head[63:32], mix_a};
		s_tail_in = head;
		unique case (state_q)
			ST_ENC: begin
				s_ctl.fwd = 1'b1;
			end
			ST_DEC: begin
				s_ctl.bwd = 1'b1;
			end
			ST_SEED: begin
				s_ctl.fwd = 1'b1;
				s_tail_in = {v_q + rc5_pkg::MAGIC_Q, v_q};
			end
			ST_MIX: begin
				l_ctl.fwd = 1'b1;
				if (cnt_q[0]) begin
					s_ctl.fwd = 1'b1;
					s_tail_in = {mix_a, head[31:0]};
				end else begin
					s_ld = 1'b1;
				end
			end
			default: begin
				l_ctl.ld = accept && (opcode == rc5_pkg::OP_EXPAND);
			end
		endcase
	end

	for (genvar i = 0; i < N; i++) begin : g_s
		rc5_pkg::cell_ctl_t c;
		always_comb begin
			c = s_ctl;
			c.ld = (i == 0) && s_ld;
		end
		rc5_cell #(.W(64)) u_cell (
			.clk(clk),
			.ctl(c),
			.next_d((i == N - 1) ? s_tail_in : sq[(i + 1) % N]),
			.prev_d(sq[(i + N - 1) % N]),
			.ld_d(s_ld_d),
			.q(sq[i])
		);
	end

	for (genvar j = 0; j < rc5_pkg::KEY_WORDS; j++) begin : g_l
		rc5_cell #(.W(32)) u_cell (
			.clk(clk),
			.ctl(l_ctl),
			.next_d((j == rc5_pkg::KEY_WORDS - 1) ? mix_b : lq[(j + 1) % rc5_pkg::KEY_WORDS]),
			.prev_d(lq[(j + rc5_pkg::KEY_WORDS - 1) % rc5_pkg::KEY_WORDS]),
			.ld_d((j < 2) ? key_low_q[32*(j%2) +: 32] : key_high_q[32*(j%2) +: 32]),
			.q(lq[j])
		);
	end

	// Key registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rc5_pkg::REG_KEY_LOW) begin
				key_low_q <= cfg_data;
			end else if (cfg_index == rc5_pkg::REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			table_ready_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (opcode == rc5_pkg::OP_EXPAND) begin
							state_q <= ST_SEED;
						end else if (opcode == rc5_pkg::OP_NONE || !table_ready_q) begin
							done_q <= 1'b1;
						end else if (opcode == rc5_pkg::OP_ENC) begin
							state_q <= ST_ENC;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_ENC, ST_DEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_PAIR) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				ST_SEED: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_PAIR) begin
						state_q <= ST_MIX;
						cnt_q <= '0;
					end
				end
				ST_MIX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_MIX) begin
						state_q <= ST_IDLE;
						table_ready_q <= 1'b1;
						done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working words and result words: block halves while ciphering, the seed value
	// while seeding the ring, the running A and B while mixing the key.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				v_q <= rc5_pkg::MAGIC_P;
				out_a_q <= '0;
				out_b_q <= '0;
				status_q <= 1'b0;
				if (opcode == rc5_pkg::OP_ENC || opcode == rc5_pkg::OP_DEC) begin
					a_q <= word_a;
					b_q <= word_b;
					status_q <= !table_ready_q;
				end else begin
					a_q <= '0;
					b_q <= '0;
				end
			end
			ST_ENC: begin
				if (cnt_q == '0) begin
					a_q <= a_q + head[31:0];
					b_q <= b_q + head[63:32];
				end else begin
					a_q <= enc_a;
					b_q <= enc_b;
				end
				out_a_q <= enc_a;
				out_b_q <= enc_b;
			end
			ST_DEC: begin
				a_q <= dec_a;
				b_q <= dec_b;
				out_a_q <= a_q - tail[31:0];
				out_b_q <= b_q - tail[63:32];
			end
			ST_SEED: begin
				v_q <= v_q + rc5_pkg::MAGIC_Q + rc5_pkg::MAGIC_Q;
				out_a_q <= '0;
				out_b_q <= '0;
			end
			ST_MIX: begin
				a_q <= mix_a;
				b_q <= mix_b;
				out_a_q <= '0;
				out_b_q <= '0;
			end
			default: begin
				out_a_q <= '0;
				out_b_q <= '0;
			end
		endcase
	end

	assign done = done_q;
	assign out_a = out_a_q;
	assign out_b = out_b_q;
	assign status = status_q;

endmodule
`default_nettype wire

@@ hw/rtl/rc5_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One storage cell of a ring: loads, or takes the word of either neighbor.
module rc5_cell #(
	parameter int W = 64
) (
	input wire logic clk,
	input wire rc5_pkg::cell_ctl_t ctl,
	input wire logic [W-1:0] next_d,
	input wire logic [W-1:0] prev_d,
	input wire logic [W-1:0] ld_d,
	output logic [W-1:0] q
);

	logic [W-1:0] word_q;

	always_ff @(posedge clk) begin
		priority if (ctl.ld) begin
			word_q <= ld_d;
		end else if (ctl.fwd) begin
			word_q <= next_d;
		end else if (ctl.bwd) begin
			word_q <= prev_d;
		end
	end

	assign q = word_q;

endmodule
`default_nettype wire

@@ hw/rtl/rc5_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Watches the ports of the cipher and checks result timing and content.
module rc5_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [1:0] opcode,
	input wire logic done,
	input wire logic [31:0] out_a,
	input wire logic [31:0] out_b,
	input wire logic status
);

	logic acc;
	assign acc = start && !busy;

	`ASSERT_NEXT(a_none_answers, clk, arst_n, acc && opcode == rc5_pkg::OP_NONE, done && out_a == '0 && out_b == '0 && !status)
	`ASSERT_SAME(a_err_zero, clk, arst_n, done && status, out_a == '0 && out_b == '0)
	`ASSERT_NEXT(a_expand_busy, clk, arst_n, acc && opcode == rc5_pkg::OP_EXPAND, busy && !done)
	`ASSERT_NEXT(a_cipher_starts, clk, arst_n, acc && (opcode == rc5_pkg::OP_ENC || opcode == rc5_pkg::OP_DEC), busy || (done && status))

endmodule

bind rc5_block_cipher_top rc5_checker u_rc5_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.opcode(opcode),
	.done(done),
	.out_a(out_a),
	.out_b(out_b),
	.status(status)
);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Self-checking bench for the RC5-32/12/16 engine.
// A queue of commands is built up front by an initial block: a directed group
// first, then random phases. Each phase writes the two key registers while the
// engine is idle, expands the key, and then runs cipher commands and noise.
// The driver presents one command word at a time with random idle bursts.
// The monitor checks every result word, field by field, against a predictor
// that keeps its own copy of the key registers and the subkey table.
module testbench;

	localparam int ROUNDS = 12;
	localparam int TBL = 2 * (ROUNDS + 1);

	// One command word, or a key register write when is_cfg is set.
	typedef struct {
		bit is_cfg;
		logic [1:0] op;
		logic [31:0] a;
		logic [31:0] b;
		logic [1:0] reg_idx;
		logic [63:0] reg_val;
	} cmd_t;

	typedef struct {
		logic [31:0] a;
		logic [31:0] b;
		logic st;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = rc5_pkg::OP_NONE;
	logic [31:0] word_a = '0;
	logic [31:0] word_b = '0;
	logic done;
	logic [31:0] out_a;
	logic [31:0] out_b;
	logic status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = rc5_pkg::REG_KEY_LOW;
	logic [63:0] cfg_data = '0;

	cmd_t pending[$];
	res_t expected_words[$];
	int mismatches = 0;
	bit stim_done = 1'b0;
	bit quiet_tail = 1'b0;

	// Predictor state.
	logic [63:0] key_lo_m = '0;
	logic [63:0] key_hi_m = '0;
	logic [31:0] subkeys[TBL];
	bit have_table = 1'b0;

	rc5_block_cipher_top #(.ROUNDS(ROUNDS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .word_a(word_a), .word_b(word_b),
		.done(done), .out_a(out_a), .out_b(out_b), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] rol(logic [31:0] x, logic [4:0] n);
		return (n == 0) ? x : ((x << n) | (x >> (6'd32 - n)));
	endfunction

	function automatic logic [31:0] ror(logic [31:0] x, logic [4:0] n);
		return (n == 0) ? x : ((x >> n) | (x << (6'd32 - n)));
	endfunction

	task automatic build_subkeys();
		logic [31:0] lw[4];
		logic [31:0] x, y;
		int i, j;
		lw[0] = key_lo_m[31:0];
		lw[1] = key_lo_m[63:32];
		lw[2] = key_hi_m[31:0];
		lw[3] = key_hi_m[63:32];
		subkeys[0] = rc5_pkg::MAGIC_P;
		for (int k = 1; k < TBL; k++)
			subkeys[k] = subkeys[k - 1] + rc5_pkg::MAGIC_Q;
		x = 0;
		y = 0;
		i = 0;
		j = 0;
		for (int k = 0; k < 3 * TBL; k++) begin
			x = rol(subkeys[i] + x + y, 5'd3);
			subkeys[i] = x;
			y = rol(lw[j] + x + y, 5'(x + y));
			lw[j] = y;
			i = (i + 1) % TBL;
			j = (j + 1) % 4;
		end
		have_table = 1'b1;
	endtask

	// Works out the result word for one accepted command.
	task automatic predict_result(cmd_t c);
		res_t r;
		logic [31:0] x, y;
		r = '{a: '0, b: '0, st: 1'b0};
		if (c.op == rc5_pkg::OP_EXPAND) begin
			build_subkeys();
		end else if (c.op == rc5_pkg::OP_NONE) begin
		end else if (!have_table) begin
			r.st = 1'b1;
		end else if (c.op == rc5_pkg::OP_ENC) begin
			x = c.a + subkeys[0];
			y = c.b + subkeys[1];
			for (int k = 1; k <= ROUNDS; k++) begin
				x = rol(x ^ y, y[4:0]) + subkeys[2 * k];
				y = rol(y ^ x, x[4:0]) + subkeys[2 * k + 1];
			end
			r.a = x;
			r.b = y;
		end else begin
			x = c.a;
			y = c.b;
			for (int k = ROUNDS; k >= 1; k--) begin
				y = ror(y - subkeys[2 * k + 1], x[4:0]) ^ x;
				x = ror(x - subkeys[2 * k], y[4:0]) ^ y;
			end
			r.a = x - subkeys[0];
			r.b = y - subkeys[1];
		end
		expected_words.push_back(r);
	endtask

	function automatic cmd_t op_cmd(logic [1:0] op, logic [31:0] a, logic [31:0] b);
		cmd_t c;
		c = '{is_cfg: 1'b0, op: op, a: a, b: b, reg_idx: rc5_pkg::REG_KEY_LOW,
			reg_val: '0};
		return c;
	endfunction

	function automatic cmd_t key_cmd(logic [1:0] idx, logic [63:0] v);
		cmd_t c;
		c = '{is_cfg: 1'b1, op: rc5_pkg::OP_NONE, a: '0, b: '0, reg_idx: idx,
			reg_val: v};
		return c;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hffffffff;
			default: return $urandom();
		endcase
	endfunction

	// Driver: commands go out on start/busy, key writes on cfg_valid/cfg_ready.
	// A key write is only issued once every expected word has come back and
	// the engine has had a full expansion time to settle.
	int idle_left = 0;
	int settle = 0;
	bit sending = 1'b0;
	bit cfg_sending = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		bit start_n, cfg_n;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
			sending = 1'b0;
			cfg_sending = 1'b0;
		end else begin
			start_n = start;
			cfg_n = cfg_valid;
			if (sending && !busy) begin
				predict_result(pending.pop_front());
				sending = 1'b0;
				start_n = 1'b0;
			end
			if (cfg_sending && cfg_ready) begin
				c = pending.pop_front();
				if (c.reg_idx == rc5_pkg::REG_KEY_LOW)
					key_lo_m = c.reg_val;
				else if (c.reg_idx == rc5_pkg::REG_KEY_HIGH)
					key_hi_m = c.reg_val;
				cfg_sending = 1'b0;
				cfg_n = 1'b0;
			end
			if (expected_words.size() != 0 || sending)
				settle = 0;
			else if (settle < 7 * (ROUNDS + 1) + 4)
				settle++;
			if (!sending && !cfg_sending && pending.size() != 0) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
					idle_left = $urandom_range(0, 2);
				end else if (pending[0].is_cfg) begin
					if (settle >= 7 * (ROUNDS + 1) + 4) begin
						cfg_index <= pending[0].reg_idx;
						cfg_data <= pending[0].reg_val;
						cfg_n = 1'b1;
						cfg_sending = 1'b1;
					end
				end else begin
					opcode <= pending[0].op;
					word_a <= pending[0].a;
					word_b <= pending[0].b;
					start_n = 1'b1;
					sending = 1'b1;
				end
			end
			start <= start_n;
			cfg_valid <= cfg_n;
			if (pending.size() == 0 && !sending && !cfg_sending)
				stim_done = 1'b1;
		end
	end

	// Monitor: every strobe is one result word that must match the oldest
	// expectation.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word a=%h b=%h status=%0d",
						out_a, out_b, status);
			end else begin
				e = expected_words.pop_front();
				if (out_a !== e.a || out_b !== e.b || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected a=%h b=%h status=%0d, got a=%h b=%h status=%0d",
							e.a, e.b, e.st, out_a, out_b, status);
				end
			end
		end
	end

	initial begin
		logic [31:0] ra, rb;
		int n;
		// Directed part: errors before any table, unused opcode, extreme keys
		// and block values, and a re-expansion.
		pending.push_back(op_cmd(rc5_pkg::OP_ENC, 32'h0, 32'hffffffff));
		pending.push_back(op_cmd(rc5_pkg::OP_DEC, 32'hffffffff, 32'h0));
		pending.push_back(op_cmd(rc5_pkg::OP_NONE, 32'hffffffff, 32'hffffffff));
		pending.push_back(op_cmd(rc5_pkg::OP_EXPAND, 32'h12345678, 32'h9abcdef0));
		pending.push_back(op_cmd(rc5_pkg::OP_ENC, 32'h0, 32'h0));
		pending.push_back(op_cmd(rc5_pkg::OP_DEC, 32'hffffffff, 32'hffffffff));
		pending.push_back(key_cmd(rc5_pkg::REG_KEY_LOW, 64'hffffffffffffffff));
		pending.push_back(key_cmd(rc5_pkg::REG_KEY_HIGH, 64'hffffffffffffffff));
		pending.push_back(op_cmd(rc5_pkg::OP_ENC, 32'h0, 32'h0));
		pending.push_back(op_cmd(rc5_pkg::OP_EXPAND, 32'h0, 32'h0));
		pending.push_back(op_cmd(rc5_pkg::OP_ENC, 32'hffffffff, 32'h0));
		pending.push_back(op_cmd(rc5_pkg::OP_DEC, 32'h0, 32'hffffffff));
		pending.push_back(op_cmd(rc5_pkg::OP_NONE, 32'h0, 32'h0));
		pending.push_back(key_cmd(rc5_pkg::REG_KEY_LOW, 64'h0706050403020100));
		pending.push_back(key_cmd(rc5_pkg::REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908));
		pending.push_back(op_cmd(rc5_pkg::OP_EXPAND, 32'hffffffff, 32'hffffffff));
		pending.push_back(op_cmd(rc5_pkg::OP_ENC, 32'h03020100, 32'h07060504));
		pending.push_back(op_cmd(rc5_pkg::OP_DEC, 32'h80000000, 32'h00000001));
		// Random phases: new key, expansion, then random encrypt and decrypt commands and noise.
		for (int p = 0; p < 12; p++) begin
			pending.push_back(key_cmd(rc5_pkg::REG_KEY_LOW, p == 0 ? 64'h0 : rand64()));
			pending.push_back(key_cmd(rc5_pkg::REG_KEY_HIGH, p == 0 ? 64'h0 : rand64()));
			pending.push_back(op_cmd(rc5_pkg::OP_EXPAND, $urandom(), $urandom()));
			n = $urandom_range(20, 40);
			for (int k = 0; k < n; k++) begin
				ra = rand_word();
				rb = rand_word();
				case ($urandom_range(0, 19))
					0: pending.push_back(op_cmd(rc5_pkg::OP_NONE, ra, rb));
					1: pending.push_back(op_cmd(rc5_pkg::OP_EXPAND, ra, rb));
					default: pending.push_back(op_cmd(
						$urandom_range(0, 1) ? rc5_pkg::OP_DEC : rc5_pkg::OP_ENC, ra, rb));
				endcase
			end
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() < 40);
		quiet_tail = 1'b1;
		wait (stim_done && expected_words.size() == 0);
		repeat (7 * (ROUNDS + 1) + 10) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("rc5_block_cipher_top test passed");
		else
			$display("rc5_block_cipher_top test failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("rc5_block_cipher_top test failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ rc5_block_cipher_top.f @@
+incdir+hw/rtl
hw/rtl/rc5_pkg.sv
hw/rtl/rc5_cell.sv
hw/rtl/rc5_block_cipher_top.sv
hw/rtl/rc5_checker.sv
tb/testbench.sv
